// ===== rtl/hse_pkg.sv =====
`default_nettype none
package hse_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [31:0] mac_word;
    logic [2:0]  word_index;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  localparam logic [1:0] FUNC_KEY_BYTE = 2'd0;
  localparam logic [1:0] FUNC_KEY_END  = 2'd1;
  localparam logic [1:0] FUNC_MSG_BYTE = 2'd2;
  localparam logic [1:0] FUNC_MSG_END  = 2'd3;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] OPAD     = 8'h5C;
  localparam logic [7:0] IPAD     = 8'h36;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hse_round.sv =====
`default_nettype none
module hse_round (
  input  wire hse_pkg::work_t cur,
  input  wire logic [6:0]     rnd,
  input  wire logic [31:0]    w0,
  input  wire logic [31:0]    w2,
  input  wire logic [31:0]    w8,
  input  wire logic [31:0]    w13,
  output hse_pkg::work_t      nxt,
  output logic [31:0]         wt
);

  logic [31:0] f;
  logic [31:0] k;

  always_comb begin
    if (rnd < 7'd16) begin
      wt = w0;
    end else begin
      wt = hse_pkg::rotl(w13 ^ w8 ^ w2 ^ w0, 1);
    end
    if (rnd < 7'd20) begin
      f = (cur.b & cur.c) | (~cur.b & cur.d);
      k = hse_pkg::K0;
    end else if (rnd < 7'd40) begin
      f = cur.b ^ cur.c ^ cur.d;
      k = hse_pkg::K1;
    end else if (rnd < 7'd60) begin
      f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
      k = hse_pkg::K2;
    end else begin
      f = cur.b ^ cur.c ^ cur.d;
      k = hse_pkg::K3;
    end
    nxt.a = hse_pkg::rotl(cur.a, 5) + f + cur.e + k + wt;
    nxt.b = cur.a;
    nxt.c = hse_pkg::rotl(cur.b, 30);
    nxt.d = cur.c;
    nxt.e = cur.d;
  end

endmodule
`default_nettype wire

// ===== rtl/hmac_sha1_engine_core.sv =====
`default_nettype none
// Streaming HMAC-SHA1 engine. Send key bytes, a key end marker, message bytes
// and a message end marker; five digest words come back, word 0 first, with
// last set on word 4. Items out of phase are dropped. Each SHA-1 compression
// runs on a single shared round unit, one round per cycle: load, 80 rounds,
// chaining add; no transfer is taken during it. A message end costs up to
// four compressions plus padding steps before the words appear.
module hmac_sha1_engine_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire hse_pkg::in_t item,
  output logic             mac_valid,
  input  wire logic        mac_stall,
  output hse_pkg::out_t    mac
);

  typedef enum logic [3:0] {
    S_IDLE, S_LONGLOAD, S_LONGBYTE, S_INIT, S_ROUND, S_FOLD, S_PAD, S_PAD2,
    S_KEYLOAD, S_KEYED, S_INNER, S_OUTLOAD, S_OUT
  } state_t;

  state_t         state;
  state_t         ret;
  state_t         fin_ret;
  logic           phase;
  logic           long_key;
  logic           opad;
  logic [60:0]    bt;
  logic [6:0]     rnd;
  logic [2:0]     idx;
  logic [7:0]     pend;
  logic [31:0]    key [16];
  logic [31:0]    blk [16];
  logic [31:0]    chain [5];
  logic [31:0]    inner [5];
  hse_pkg::work_t work;
  hse_pkg::work_t work_next;
  logic [31:0]    wt;
  logic [5:0]     pos;
  logic [63:0]    len;
  logic [1:0]     lane;
  logic [7:0]     padv;

  hse_round u_round (
    .cur (work),
    .rnd (rnd),
    .w0  (blk[0]),
    .w2  (blk[2]),
    .w8  (blk[8]),
    .w13 (blk[13]),
    .nxt (work_next),
    .wt  (wt)
  );

  assign pos        = bt[5:0];
  assign len        = {bt, 3'b000};
  assign lane       = 2'd3 - bt[1:0];
  assign padv       = opad ? hse_pkg::OPAD : hse_pkg::IPAD;
  assign item_stall = (state != S_IDLE);
  assign mac_valid  = (state == S_OUT);
  assign mac.mac_word   = chain[idx];
  assign mac.word_index = idx;
  assign mac.last       = (idx == hse_pkg::LAST_WORD);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret      <= S_IDLE;
      fin_ret  <= S_IDLE;
      phase    <= 1'b0;
      long_key <= 1'b0;
      opad     <= 1'b0;
      bt       <= '0;
      rnd      <= '0;
      idx      <= '0;
      for (int i = 0; i < 16; i++) key[i] <= '0;
      chain[0] <= hse_pkg::IV0;
      chain[1] <= hse_pkg::IV1;
      chain[2] <= hse_pkg::IV2;
      chain[3] <= hse_pkg::IV3;
      chain[4] <= hse_pkg::IV4;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            if (!phase) begin
              if (item.func == hse_pkg::FUNC_KEY_BYTE) begin
                if (!long_key && bt[60:6] == '0) begin
                  key[bt[5:2]][{lane, 3'b000} +: 8] <= item.data_byte;
                  bt <= bt + 61'd1;
                end else if (!long_key) begin
                  pend  <= item.data_byte;
                  state <= S_LONGLOAD;
                end else begin
                  blk[bt[5:2]][{lane, 3'b000} +: 8] <= item.data_byte;
                  bt <= bt + 61'd1;
                  if (pos == 6'd63) begin
                    ret   <= S_IDLE;
                    state <= S_INIT;
                  end
                end
              end else if (item.func == hse_pkg::FUNC_KEY_END) begin
                if (long_key) begin
                  fin_ret <= S_KEYLOAD;
                  state   <= S_PAD;
                end else begin
                  state <= S_KEYED;
                end
              end
            end else begin
              if (item.func == hse_pkg::FUNC_MSG_BYTE) begin
                blk[bt[5:2]][{lane, 3'b000} +: 8] <= item.data_byte;
                bt <= bt + 61'd1;
                if (pos == 6'd63) begin
                  ret   <= S_IDLE;
                  state <= S_INIT;
                end
              end else if (item.func == hse_pkg::FUNC_MSG_END) begin
                fin_ret <= S_INNER;
                state   <= S_PAD;
              end
            end
          end
        end
        S_LONGLOAD: begin
          for (int i = 0; i < 16; i++) blk[i] <= key[i];
          chain[0] <= hse_pkg::IV0;
          chain[1] <= hse_pkg::IV1;
          chain[2] <= hse_pkg::IV2;
          chain[3] <= hse_pkg::IV3;
          chain[4] <= hse_pkg::IV4;
          ret      <= S_LONGBYTE;
          state    <= S_INIT;
        end
        S_LONGBYTE: begin
          blk[bt[5:2]][{lane, 3'b000} +: 8] <= pend;
          bt       <= bt + 61'd1;
          long_key <= 1'b1;
          state    <= S_IDLE;
        end
        S_INIT: begin
          work  <= '{a: chain[0], b: chain[1], c: chain[2], d: chain[3], e: chain[4]};
          rnd   <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          work <= work_next;
          for (int i = 0; i < 15; i++) blk[i] <= blk[i + 1];
          blk[15] <= wt;
          rnd     <= rnd + 7'd1;
          if (rnd == hse_pkg::LAST_ROUND) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + work.a;
          chain[1] <= chain[1] + work.b;
          chain[2] <= chain[2] + work.c;
          chain[3] <= chain[3] + work.d;
          chain[4] <= chain[4] + work.e;
          state    <= ret;
        end
        S_PAD: begin
          for (int j = 0; j < 64; j++) begin
            if (pos < 6'd56 && j >= 56) begin
              blk[j / 4][8 * (3 - (j % 4)) +: 8] <= len[8 * (63 - j) +: 8];
            end else if (6'(j) == pos) begin
              blk[j / 4][8 * (3 - (j % 4)) +: 8] <= hse_pkg::PAD_BYTE;
            end else if (6'(j) > pos) begin
              blk[j / 4][8 * (3 - (j % 4)) +: 8] <= 8'h00;
            end
          end
          if (pos < 6'd56) begin
            ret <= fin_ret;
          end else begin
            ret <= S_PAD2;
          end
          state <= S_INIT;
        end
        S_PAD2: begin
          for (int i = 0; i < 14; i++) blk[i] <= '0;
          blk[14] <= len[63:32];
          blk[15] <= len[31:0];
          ret     <= fin_ret;
          state   <= S_INIT;
        end
        S_KEYLOAD: begin
          for (int i = 0; i < 16; i++) begin
            key[i] <= (i < 5) ? chain[i % 5] : 32'h0;
          end
          state <= S_KEYED;
        end
        S_KEYED: begin
          for (int i = 0; i < 16; i++) blk[i] <= key[i] ^ {4{padv}};
          chain[0] <= hse_pkg::IV0;
          chain[1] <= hse_pkg::IV1;
          chain[2] <= hse_pkg::IV2;
          chain[3] <= hse_pkg::IV3;
          chain[4] <= hse_pkg::IV4;
          bt       <= 61'd64;
          if (opad) begin
            ret <= S_OUTLOAD;
          end else begin
            phase <= 1'b1;
            ret   <= S_IDLE;
          end
          state <= S_INIT;
        end
        S_INNER: begin
          for (int i = 0; i < 5; i++) inner[i] <= chain[i];
          opad  <= 1'b1;
          state <= S_KEYED;
        end
        S_OUTLOAD: begin
          for (int i = 0; i < 5; i++) blk[i] <= inner[i];
          bt      <= 61'd84;
          fin_ret <= S_OUT;
          idx     <= '0;
          state   <= S_PAD;
        end
        S_OUT: begin
          if (!mac_stall) begin
            idx <= idx + 3'd1;
            if (idx == hse_pkg::LAST_WORD) begin
              for (int i = 0; i < 16; i++) key[i] <= '0;
              chain[0] <= hse_pkg::IV0;
              chain[1] <= hse_pkg::IV1;
              chain[2] <= hse_pkg::IV2;
              chain[3] <= hse_pkg::IV3;
              chain[4] <= hse_pkg::IV4;
              long_key <= 1'b0;
              bt       <= '0;
              phase    <= 1'b0;
              opad     <= 1'b0;
              state    <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_round_to_fold: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROUND && rnd == hse_pkg::LAST_ROUND) |=> (state == S_FOLD))
    else $error("Compression did not end after the last round.");

  a_out_in_message: assert property (@(posedge clk) disable iff (rst)
    mac_valid |-> (phase && opad))
    else $error("Digest word presented outside the outer hash.");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (mac_valid && !mac_stall && mac.last) |=> (!mac_valid && !phase && bt == '0))
    else $error("State not cleared after the final digest word transfer.");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (mac_valid && !mac_stall && !mac.last) |=>
      (mac_valid && mac.word_index == $past(mac.word_index) + 3'd1))
    else $error("Digest words out of order.");
`endif

endmodule
`default_nettype wire
